[src/binomial_cdf_table_top_defines.svh]
`ifndef BINOMIAL_CDF_TABLE_TOP_DEFINES_SVH
`define BINOMIAL_CDF_TABLE_TOP_DEFINES_SVH

// Same-cycle implication.
`define BCT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bct: check failed");

// Next-cycle implication.
`define BCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bct: check failed");

`endif

[src/bct_pkg.sv]
package bct_pkg;

  localparam int FRAC_BITS = 32;
  localparam int FX_W      = FRAC_BITS + 1;
  localparam int N_W       = 6;
  localparam int N_ENTRIES = 1 << N_W;
  localparam int COEFF_W   = 60;
  localparam int SCALE_W   = COEFF_W + N_W;
  localparam int TZ_W      = 3;

  localparam int MUL_DIG_W  = 16;
  localparam int MUL_DIGITS = 4;
  localparam int MUL_A_W    = MUL_DIG_W * MUL_DIGITS;
  localparam int MUL_B_W    = COEFF_W;
  localparam int MUL_PP_W   = MUL_DIG_W + MUL_B_W;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W  = 3;

  localparam logic [FX_W-1:0] FX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic [N_W-1:0]  trials;
    logic [FX_W-1:0] success_prob;
  } req_t;

  typedef struct packed {
    logic [N_W-1:0]  success_count;
    logic [FX_W-1:0] cumulative;
    logic            last;
  } res_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_cmd_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  typedef logic [N_ENTRIES-1:0][COEFF_W-1:0] inv_tab_t;
  typedef logic [N_ENTRIES-1:0][TZ_W-1:0]    tz_tab_t;

  // Inverse of the odd part of d, modulo 2^COEFF_W (Newton iteration).
  function automatic inv_tab_t build_inv_tab();
    inv_tab_t    tab;
    logic [63:0] d;
    logic [63:0] x;
    for (int i = 0; i < N_ENTRIES; i++) begin
      d = (i == 0) ? 64'd1 : 64'(i);
      for (int s = 0; s < N_W; s++) begin
        if (!d[0]) begin
          d = d >> 1;
        end
      end
      x = d;
      for (int s = 0; s < 6; s++) begin
        x = x * (64'd2 - d * x);
      end
      tab[i] = x[COEFF_W-1:0];
    end
    return tab;
  endfunction

  // Trailing zero count of d.
  function automatic tz_tab_t build_tz_tab();
    tz_tab_t     tab;
    logic [63:0] d;
    logic [TZ_W-1:0] z;
    for (int i = 0; i < N_ENTRIES; i++) begin
      d = (i == 0) ? 64'd1 : 64'(i);
      z = '0;
      for (int s = 0; s < N_W; s++) begin
        if (!d[0]) begin
          d = d >> 1;
          z = z + 1'b1;
        end
      end
      tab[i] = z;
    end
    return tab;
  endfunction

  localparam inv_tab_t INV_TAB = build_inv_tab();
  localparam tz_tab_t  TZ_TAB  = build_tz_tab();

endpackage

[src/binomial_cdf_table_top.sv]
// Binomial CDF table: n+1 results per request, one for each k = 0..n.
// The (1-p)^j table is filled first, one product per entry after entry 0; each result
// then takes its own chain of products, the last result a shorter chain than the rest.
// A request is taken only in idle, once the last result is registered; output stalls
// delay that. All products run through one shared 16x60 digit-serial multiplier (4 digits).
// Reset (rst, synchronous) clears control state only; the power table is not cleared.
module binomial_cdf_table_top #(
  parameter int MAX_TRIALS = 63
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bct_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output bct_pkg::res_t res
);

  localparam int ADDR_W = $clog2(MAX_TRIALS + 1);
  localparam int FX_W   = bct_pkg::FX_W;
  localparam int N_W    = bct_pkg::N_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_FILL_WAIT,
    S_READ,
    S_PROD,
    S_PROD_WAIT,
    S_TERM_WAIT,
    S_EMIT,
    S_SCALE_WAIT,
    S_DIV_WAIT,
    S_POW_WAIT
  } state_t;

  state_t                         state;
  logic [N_W-1:0]                 n_trials;
  logic [FX_W-1:0]                prob;
  logic [FX_W-1:0]                fail_prob;
  logic [N_W-1:0]                 fill_idx;
  logic [FX_W-1:0]                fill_prev;
  logic [N_W-1:0]                 step_index;
  logic [bct_pkg::COEFF_W-1:0]    binom_coeff;
  logic [FX_W-1:0]                running_sum;
  logic [FX_W-1:0]                prob_power;
  bct_pkg::mul_cmd_t              mul_cmd;
  bct_pkg::mul_rsp_t              mul_rsp;

  logic                           req_xfer;
  logic                           mul_go;
  logic [N_W-1:0]                 n_sat;
  logic [FX_W-1:0]                p_sat;
  logic [FX_W-1:0]                mul_fx;
  logic [FX_W-1:0]                term;
  logic [FX_W:0]                  sum_wide;
  logic [N_W-1:0]                 read_idx;
  logic [N_W-1:0]                 divisor;
  logic [bct_pkg::SCALE_W-1:0]    scaled;
  logic                           ram_we;
  logic [ADDR_W-1:0]              ram_waddr;
  logic [FX_W-1:0]                ram_wdata;
  logic [FX_W-1:0]                ram_rdata;

  assign req_ready = (state == S_IDLE);
  assign req_xfer  = req_valid && req_ready;

  assign n_sat = (req.trials > N_W'(MAX_TRIALS)) ? N_W'(MAX_TRIALS) : req.trials;
  assign p_sat = (req.success_prob > bct_pkg::FX_ONE) ? bct_pkg::FX_ONE : req.success_prob;

  assign mul_fx   = mul_rsp.prod[bct_pkg::FRAC_BITS +: FX_W];
  assign term     = (mul_rsp.prod > bct_pkg::MUL_P_W'(bct_pkg::FX_ONE))
                    ? bct_pkg::FX_ONE : mul_rsp.prod[FX_W-1:0];
  assign sum_wide = {1'b0, running_sum} + {1'b0, term};

  assign read_idx = n_trials - step_index;
  assign divisor  = step_index + 1'b1;
  assign scaled   = mul_rsp.prod[bct_pkg::SCALE_W-1:0] >> bct_pkg::TZ_TAB[divisor];

  assign mul_go = (state == S_FILL) || (state == S_PROD)
                  || (mul_rsp.done && (state inside {S_PROD_WAIT, S_SCALE_WAIT, S_DIV_WAIT}))
                  || (state == S_EMIT && (!res_valid || res_ready)
                      && step_index != n_trials);

  // Entry 0 is written on the request transfer, the rest as products finish.
  assign ram_we    = req_xfer || (state == S_FILL_WAIT && mul_rsp.done);
  assign ram_waddr = req_xfer ? '0 : fill_idx[ADDR_W-1:0];
  assign ram_wdata = req_xfer ? bct_pkg::FX_ONE : mul_fx;

  bct_ram #(
    .WIDTH (FX_W),
    .DEPTH (MAX_TRIALS + 1),
    .ADDR_W(ADDR_W)
  ) u_fail_pow (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(read_idx[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  bct_mul u_mul (
    .clk(clk),
    .rst(rst),
    .cmd(mul_cmd),
    .rsp(mul_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      res_valid     <= 1'b0;
      mul_cmd.start <= 1'b0;
    end else begin
      mul_cmd.start <= mul_go;
      if (res_ready && state != S_EMIT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            n_trials    <= n_sat;
            prob        <= p_sat;
            fail_prob   <= bct_pkg::FX_ONE - p_sat;
            fill_idx    <= N_W'(1);
            fill_prev   <= bct_pkg::FX_ONE;
            step_index  <= '0;
            binom_coeff <= bct_pkg::COEFF_W'(1);
            running_sum <= '0;
            prob_power  <= bct_pkg::FX_ONE;
            state       <= (n_sat == '0) ? S_READ : S_FILL;
          end
        end
        S_FILL: begin
          mul_cmd.a <= bct_pkg::MUL_A_W'(fill_prev);
          mul_cmd.b <= bct_pkg::MUL_B_W'(fail_prob);
          state     <= S_FILL_WAIT;
        end
        S_FILL_WAIT: begin
          if (mul_rsp.done) begin
            fill_prev <= mul_fx;
            if (fill_idx == n_trials) begin
              state <= S_READ;
            end else begin
              fill_idx <= fill_idx + 1'b1;
              state    <= S_FILL;
            end
          end
        end
        S_READ: begin
          state <= S_PROD;
        end
        S_PROD: begin
          mul_cmd.a <= bct_pkg::MUL_A_W'(prob_power);
          mul_cmd.b <= bct_pkg::MUL_B_W'(ram_rdata);
          state     <= S_PROD_WAIT;
        end
        S_PROD_WAIT: begin
          if (mul_rsp.done) begin
            mul_cmd.a <= bct_pkg::MUL_A_W'(binom_coeff);
            mul_cmd.b <= bct_pkg::MUL_B_W'(mul_fx);
            state     <= S_TERM_WAIT;
          end
        end
        S_TERM_WAIT: begin
          if (mul_rsp.done) begin
            running_sum <= (sum_wide > {1'b0, bct_pkg::FX_ONE})
                           ? bct_pkg::FX_ONE : sum_wide[FX_W-1:0];
            state       <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!res_valid || res_ready) begin
            res_valid         <= 1'b1;
            res.success_count <= step_index;
            res.cumulative    <= running_sum;
            res.last          <= (step_index == n_trials);
            if (step_index == n_trials) begin
              state <= S_IDLE;
            end else begin
              mul_cmd.a <= bct_pkg::MUL_A_W'(binom_coeff);
              mul_cmd.b <= bct_pkg::MUL_B_W'(read_idx);
              state     <= S_SCALE_WAIT;
            end
          end
        end
        S_SCALE_WAIT: begin
          // exact divide by k+1: drop its factors of two, then times odd inverse
          if (mul_rsp.done) begin
            mul_cmd.a <= bct_pkg::MUL_A_W'(bct_pkg::INV_TAB[divisor]);
            mul_cmd.b <= scaled[bct_pkg::COEFF_W-1:0];
            state     <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (mul_rsp.done) begin
            binom_coeff <= mul_rsp.prod[bct_pkg::COEFF_W-1:0];
            mul_cmd.a   <= bct_pkg::MUL_A_W'(prob_power);
            mul_cmd.b   <= bct_pkg::MUL_B_W'(prob);
            state       <= S_POW_WAIT;
          end
        end
        S_POW_WAIT: begin
          if (mul_rsp.done) begin
            prob_power <= mul_fx;
            step_index <= step_index + 1'b1;
            state      <= S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/bct_ram.sv]
module bct_ram #(
  parameter int WIDTH  = 33,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/bct_mul.sv]
module bct_mul (
  input  logic               clk,
  input  logic               rst,
  input  bct_pkg::mul_cmd_t  cmd,
  output bct_pkg::mul_rsp_t  rsp
);

  logic [bct_pkg::MUL_A_W-1:0]   a_sh;
  logic [bct_pkg::MUL_B_W-1:0]   b_hold;
  logic [bct_pkg::MUL_PP_W-1:0]  pp;
  logic [bct_pkg::MUL_P_W-1:0]   acc;
  logic [bct_pkg::MUL_CNT_W-1:0] cnt;
  logic                          busy;
  logic                          done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == bct_pkg::MUL_CNT_W'(bct_pkg::MUL_DIGITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // MSB digit first; partial product registered, then shifted into acc.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_sh   <= cmd.a;
      b_hold <= cmd.b;
      acc    <= '0;
    end else if (busy) begin
      if (cnt < bct_pkg::MUL_CNT_W'(bct_pkg::MUL_DIGITS)) begin
        pp <= bct_pkg::MUL_PP_W'(a_sh[bct_pkg::MUL_A_W-1 -: bct_pkg::MUL_DIG_W])
              * bct_pkg::MUL_PP_W'(b_hold);
        a_sh <= a_sh << bct_pkg::MUL_DIG_W;
      end
      if (cnt != '0) begin
        acc <= (acc << bct_pkg::MUL_DIG_W) + bct_pkg::MUL_P_W'(pp);
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

[src/bct_checker.sv]
`include "binomial_cdf_table_top_defines.svh"

module bct_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input bct_pkg::req_t req,
  input logic          res_valid,
  input logic          res_ready,
  input bct_pkg::res_t res
);

  `BCT_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req))
  `BCT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))
  `BCT_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
  `BCT_ASSERT_SAME(a_busy_mid_item, res_valid && !res.last, !req_ready)
  `BCT_ASSERT_SAME(a_sum_bound, res_valid, res.cumulative <= bct_pkg::FX_ONE)

endmodule

bind binomial_cdf_table_top bct_checker u_bct_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req      (req),
  .res_valid(res_valid),
  .res_ready(res_ready),
  .res      (res)
);
